// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the min/max stack RTL. The checks are compiled
// out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MMS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

`define MMS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("%m: implication failed");

`else

`define MMS_ASSERT(label, clk, rst_n, prop)

`define MMS_ASSERT_IMPL(label, clk, rst_n, pre, post)

`endif

`endif

// ===== hdl/mms_pkg.sv =====
// ---------------------------------------------------------------------------
// mms_pkg
// Types and constants of the min/max stack.
// ---------------------------------------------------------------------------
package mms_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int COUNT_W     = 7;
	localparam int CMD_W       = 2;
	localparam int ERR_W       = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_NOP  = 2'd2
	} mms_cmd_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} mms_err_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic signed [DATA_W-1:0] max;
		logic signed [DATA_W-1:0] min;
	} mms_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} mms_shift_t;

endpackage

// ===== hdl/mms_if.sv =====
// ---------------------------------------------------------------------------
// mms_if
// Request and response channels of the min/max stack, valid/ready handshake.
// ---------------------------------------------------------------------------
interface mms_req_if
	import mms_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

interface mms_rsp_if
	import mms_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] top_value;
	logic signed [DATA_W-1:0] top_max;
	logic signed [DATA_W-1:0] top_min;
	logic [COUNT_W-1:0]       count;
	logic                     is_empty;
	logic [ERR_W-1:0]         error;

	modport source (output valid, output top_value, output top_max, output top_min,
		output count, output is_empty, output error, input ready);
	modport sink (input valid, input top_value, input top_max, input top_min,
		input count, input is_empty, input error, output ready);
endinterface

// ===== hdl/min_max_stack.sv =====
// ---------------------------------------------------------------------------
// min_max_stack
// LIFO of signed 32-bit values; every slot keeps the running max and min.
// ---------------------------------------------------------------------------
// The stack is a row of STACK_DEPTH slots, the top in slot 0; a push shifts
// every slot down by one and a pop shifts them up. A request is taken
// whenever the response register is free or being drained, giving one
// request per cycle and a registered response, valid in the cycle after
// the request. Pop on an empty stack and push on a full one are reported in
// error and leave the stack untouched. Slot contents are not reset; only
// the fill count and the response valid flag are.
`include "assert_macros.svh"

module min_max_stack
	import mms_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	mms_req_if.sink         req,
	mms_rsp_if.source       rsp
);

	localparam logic [DEPTH_W-1:0] FULL_COUNT = DEPTH_W'(STACK_DEPTH);

	mms_entry_t        cells [STACK_DEPTH];
	mms_entry_t        push_entry;
	mms_entry_t        next_top;
	mms_shift_t        shift;
	mms_err_t          err;
	logic              accept;
	logic              is_push;
	logic              is_pop;
	logic              full;
	logic              empty;
	logic [DEPTH_W-1:0] depth_next;

	logic [DEPTH_W-1:0] depth_q;
	logic               rsp_valid_q;
	mms_entry_t         top_q;
	logic [COUNT_W-1:0] count_q;
	logic               empty_q;
	mms_err_t           err_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_push   = (req.cmd == CMD_PUSH);
	assign is_pop    = (req.cmd == CMD_POP);
	assign full      = (depth_q == FULL_COUNT);
	assign empty     = (depth_q == '0);

	always_comb begin
		push_entry.val = req.value;
		push_entry.max = req.value;
		push_entry.min = req.value;
		if (!empty) begin
			if (cells[0].max > req.value) begin
				push_entry.max = cells[0].max;
			end
			if (cells[0].min < req.value) begin
				push_entry.min = cells[0].min;
			end
		end
	end

	always_comb begin
		shift      = '0;
		err        = ERR_OK;
		depth_next = depth_q;
		next_top   = empty ? '0 : cells[0];
		priority if (is_push) begin
			if (full) begin
				err = ERR_FULL;
			end else begin
				shift.push = accept;
				depth_next = depth_q + 1'b1;
				next_top   = push_entry;
			end
		end else if (is_pop) begin
			if (empty) begin
				err = ERR_EMPTY;
			end else begin
				shift.pop  = accept;
				depth_next = depth_q - 1'b1;
				next_top   = (depth_q == DEPTH_W'(1)) ? '0 : cells[1];
			end
		end else begin
			err = ERR_OK;
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		mms_entry_t above;
		mms_entry_t below;
		if (i == 0) begin : g_top
			assign above = push_entry;
		end else begin : g_mid
			assign above = cells[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_bottom
			assign below = cells[i];
		end else begin : g_upper
			assign below = cells[i+1];
		end
		mms_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.from_above (above),
			.from_below (below),
			.entry      (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				depth_q     <= depth_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			top_q   <= next_top;
			count_q <= COUNT_W'(depth_next);
			empty_q <= (depth_next == '0);
			err_q   <= err;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.top_value = top_q.val;
	assign rsp.top_max   = top_q.max;
	assign rsp.top_min   = top_q.min;
	assign rsp.count     = count_q;
	assign rsp.is_empty  = empty_q;
	assign rsp.error     = err_q;

	`MMS_ASSERT(a_depth_bound, clk, arst_n, depth_q <= FULL_COUNT)
	`MMS_ASSERT_IMPL(a_push_grows, clk, arst_n, accept && is_push && !full,
		##1 depth_q == $past(depth_q) + 1'b1)
	`MMS_ASSERT_IMPL(a_full_flag, clk, arst_n, rsp_valid_q && err_q == ERR_FULL,
		depth_q == FULL_COUNT)
	`MMS_ASSERT_IMPL(a_empty_flag, clk, arst_n, rsp_valid_q,
		empty_q == (depth_q == '0))
	`MMS_ASSERT_IMPL(a_max_ge_min, clk, arst_n, rsp_valid_q && !empty_q,
		top_q.max >= top_q.min)

endmodule

// ===== hdl/mms_cell.sv =====
// ---------------------------------------------------------------------------
// mms_cell
// One stack slot: takes the entry above on push, the entry below on pop.
// ---------------------------------------------------------------------------
module mms_cell
	import mms_pkg::*;
(
	input  logic       clk,
	input  mms_shift_t shift,
	input  mms_entry_t from_above,
	input  mms_entry_t from_below,
	output mms_entry_t entry
);

	mms_entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift.push) begin
			entry_q <= from_above;
		end else if (shift.pop) begin
			entry_q <= from_below;
		end
	end

	assign entry = entry_q;

endmodule

// ===== tb/min_max_stack_test.sv =====
// ---------------------------------------------------------------------------
// min_max_stack_test
// Self-checking bench for the min/max stack. A predictor keeps its own copy
// of the stack and works out the report for each accepted request; every
// response is compared field by field with the oldest pending report.
// Directed corner cases come first: empty and full stack, value extremes,
// ties and the unused command. Long random walks over the stack depth
// follow, with random idling on both channels, one long response hold-off
// and a final stretch without idling.
// ---------------------------------------------------------------------------
module min_max_stack_test
	import mms_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_SHOWN   = 10;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] top_max;
		logic signed [DATA_W-1:0] top_min;
		logic [COUNT_W-1:0]       count;
		logic                     is_empty;
		logic [ERR_W-1:0]         error;
	} stack_report_t;

	logic clk;
	logic arst_n;

	mms_req_if req_ch ();
	mms_rsp_if rsp_ch ();

	min_max_stack u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	mms_entry_t    shadow_stack [STACK_DEPTH];
	int unsigned   shadow_fill;
	stack_report_t report_q [$];
	int            mismatch_cnt;
	int            cycle_cnt;
	bit            gap_on;
	bit            stall_on;
	int            hold_len;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic stack_report_t apply_command(input logic [CMD_W-1:0] op,
			input logic signed [DATA_W-1:0] operand);
		stack_report_t            rep;
		logic signed [DATA_W-1:0] run_max;
		logic signed [DATA_W-1:0] run_min;
		mms_entry_t               below;

		rep.error = ERR_OK;
		if (op == CMD_PUSH) begin
			if (shadow_fill >= STACK_DEPTH) begin
				rep.error = ERR_FULL;
			end else begin
				run_max = operand;
				run_min = operand;
				if (shadow_fill > 0) begin
					below = shadow_stack[shadow_fill - 1];
					if (below.max < operand) begin
						run_min = below.min;
					end else begin
						run_max = below.max;
						run_min = (below.min >= operand) ? operand : below.min;
					end
				end
				shadow_stack[shadow_fill] = '{val: operand, max: run_max, min: run_min};
				shadow_fill++;
			end
		end else if (op == CMD_POP) begin
			if (shadow_fill == 0)
				rep.error = ERR_EMPTY;
			else
				shadow_fill--;
		end

		if (shadow_fill > 0) begin
			rep.top_value = shadow_stack[shadow_fill - 1].val;
			rep.top_max   = shadow_stack[shadow_fill - 1].max;
			rep.top_min   = shadow_stack[shadow_fill - 1].min;
		end else begin
			rep.top_value = '0;
			rep.top_max   = '0;
			rep.top_min   = '0;
		end
		rep.count    = shadow_fill[COUNT_W-1:0];
		rep.is_empty = (shadow_fill == 0);
		return rep;
	endfunction

	always @(posedge clk) begin : monitor
		stack_report_t want;
		stack_report_t got;

		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				report_q.push_back(apply_command(req_ch.cmd, req_ch.value));
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{top_value: rsp_ch.top_value, top_max: rsp_ch.top_max,
					top_min: rsp_ch.top_min, count: rsp_ch.count,
					is_empty: rsp_ch.is_empty, error: rsp_ch.error};
				if (report_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_SHOWN)
						$display("%0t: response with no request pending", $realtime);
				end else begin
					want = report_q.pop_front();
					if (got.top_value !== want.top_value || got.top_max !== want.top_max ||
							got.top_min !== want.top_min || got.count !== want.count ||
							got.is_empty !== want.is_empty || got.error !== want.error) begin
						mismatch_cnt++;
						if (mismatch_cnt <= MAX_SHOWN) begin
							$display("%0t: mismatch exp val %0d max %0d min %0d cnt %0d empty %0d err %0d",
								$realtime, want.top_value, want.top_max, want.top_min,
								want.count, want.is_empty, want.error);
							$display("%0t: mismatch got val %0d max %0d min %0d cnt %0d empty %0d err %0d",
								$realtime, got.top_value, got.top_max, got.top_min,
								got.count, got.is_empty, got.error);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("min_max_stack_test: errors");
			$finish;
		end
	end

	initial begin : response_sink
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
				rsp_ch.ready <= 1'b1;
			end else if (stall_on && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_request(input logic [CMD_W-1:0] op,
			input logic signed [DATA_W-1:0] operand);
		int gap;

		if (gap_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd   <= op;
		req_ch.value <= operand;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		int sel;

		sel = $urandom_range(0, 9);
		if (sel < 4)
			return $urandom;
		else if (sel < 7)
			return $urandom_range(0, 6) - 3;
		else if (sel < 8)
			return 32'sh8000_0000;
		else if (sel < 9)
			return 32'sh7fff_ffff;
		else
			return $urandom_range(0, 1) ? 32'sh0 : -32'sh1;
	endfunction

	task automatic test_corners();
		send_request(CMD_NOP, 32'sh0);
		send_request(CMD_POP, $urandom);
		send_request(CMD_SPARE, $urandom);
		send_request(CMD_PUSH, 32'sh8000_0000);
		send_request(CMD_PUSH, 32'sh7fff_ffff);
		send_request(CMD_PUSH, 32'sh0);
		send_request(CMD_PUSH, -32'sh1);
		send_request(CMD_PUSH, -32'sh1);
		send_request(CMD_PUSH, 32'sh8000_0000);
		send_request(CMD_NOP, $urandom);
		send_request(CMD_SPARE, 32'sh5555_aaaa);
		repeat (6) send_request(CMD_POP, $urandom);
		send_request(CMD_POP, 32'shffff_ffff);
		send_request(CMD_PUSH, 32'sh7fff_ffff);
		send_request(CMD_PUSH, 32'sh7fff_ffff);
		send_request(CMD_POP, 32'sh0);
		send_request(CMD_POP, 32'sh0);
	endtask

	task automatic test_full_stack();
		repeat (STACK_DEPTH + 3) send_request(CMD_PUSH, pick_value());
		send_request(CMD_NOP, $urandom);
		repeat (STACK_DEPTH + 3) send_request(CMD_POP, $urandom);
	endtask

	task automatic random_walk(input int n_items);
		int bias;
		int push_pct;
		int roll;

		bias = $urandom_range(0, 2);
		push_pct = (bias == 0) ? 75 : (bias == 1) ? 20 : 47;
		repeat (n_items) begin
			roll = $urandom_range(0, 99);
			if (roll < push_pct)
				send_request(CMD_PUSH, pick_value());
			else if (roll < 94)
				send_request(CMD_POP, $urandom);
			else if (roll < 97)
				send_request(CMD_NOP, $urandom);
			else
				send_request(CMD_SPARE, $urandom);
		end
	endtask

	task automatic test_random();
		repeat (8) random_walk(100);
	endtask

	task automatic test_backpressure();
		gap_on = 1'b0;
		hold_len = 300;
		random_walk(150);
		gap_on = 1'b1;
	endtask

	task automatic test_no_idle();
		gap_on   = 1'b0;
		stall_on = 1'b0;
		repeat (2) random_walk(100);
	endtask

	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd   = CMD_NOP;
		req_ch.value = '0;
		shadow_fill  = 0;
		mismatch_cnt = 0;
		cycle_cnt    = 0;
		hold_len     = 0;
		gap_on       = 1'b1;
		stall_on     = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_full_stack();
		test_random();
		test_backpressure();
		test_random();
		test_no_idle();

		req_ch.valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_cnt == 0 && report_q.size() == 0)
			$display("min_max_stack_test: clean");
		else
			$display("min_max_stack_test: errors");
		$finish;
	end

endmodule

// ===== min_max_stack.f =====
+incdir+hdl
hdl/mms_pkg.sv
hdl/mms_if.sv
hdl/mms_cell.sv
hdl/min_max_stack.sv
tb/min_max_stack_test.sv
